[rtl/elastic_pair_collision_defines.svh]
// Assertion macros for the elastic pair collision block.
// Needs a clk and an active-low arst_n in the scope of each use.
`ifndef ELASTIC_PAIR_COLLISION_DEFINES_SVH
`define ELASTIC_PAIR_COLLISION_DEFINES_SVH

// Clocked property, off while reset is held.
`define EPC_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Same-cycle implication.
`define EPC_IMPLIES(lbl, ante, cons, msg) `EPC_ASSERT(lbl, (ante) |-> (cons), msg)

`endif

[rtl/epc_pkg.sv]
// Types and constants of the elastic pair collision pipeline.
// No dependencies; imported by elastic_pair_collision and its testbench.
package epc_pkg;

	localparam int QW = 18;                   // quotient bits of |c| in Q.8
	localparam int DW = 41;                   // squared distance, Q.16
	localparam int NW = 59;                   // rounded numerator magnitude, Q.24
	localparam int NS = QW + 7;               // pipeline stages, divider included
	localparam logic [37:0] LIMIT_RST = 38'd26214400; // (2*2560)^2

	typedef struct packed {
		logic signed [15:0] v1x;
		logic signed [15:0] v1y;
		logic signed [15:0] v2x;
		logic signed [15:0] v2y;
		logic [15:0]        c1;
		logic [15:0]        c2;
	} pass_t;

	typedef struct packed {
		pass_t          pass;
		logic           contact;
		logic           resolved;
		logic           sx;           // x correction adds to the first velocity
		logic           sy;
		logic [DW-1:0]  den;
		logic [NW-1:0]  rx;
		logic [NW-1:0]  ry;
		logic [QW-1:0]  qx;
		logic [QW-1:0]  qy;
	} div_t;

endpackage

[rtl/elastic_pair_collision.sv]
// Elastic pair collision: top level, full pipeline in one module.
// Depends on epc_pkg and elastic_pair_collision_defines.svh.
//
// Response of a pair of equal-mass circles. A beat on the s_ side carries both
// circles; one beat leaves on the m_ side for each, in order. One pair is
// taken every cycle unless the output stalls with all stages full: six stages
// form differences, products, the contact test and the rounded numerators,
// then two restoring dividers (x and y) produce one quotient bit per stage
// over 18 stages, and a last stage applies, clamps and swaps. Each stage holds
// its own valid bit and loads when it is empty or the stage after it moves, so
// bubbles close up and a stalled output does not stop input while any stage
// is free. The contact radius is written through cfg_we/cfg_wdata; the block
// keeps (2*radius)^2, so a pair may follow the write in the next cycle.
`include "elastic_pair_collision_defines.svh"

module elastic_pair_collision
	import epc_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic [17:0]  cfg_wdata,      // contact_radius, unsigned Q10.8
	input  logic         s_tvalid,
	output logic         s_tready,
	// first_pos_x, first_pos_y, first_vel_x, first_vel_y, first_color,
	// second_pos_x, second_pos_y, second_vel_x, second_vel_y, second_color
	input  logic [175:0] s_tdata,
	output logic         m_tvalid,
	input  logic         m_tready,
	// new_first_vel_x, new_first_vel_y, new_second_vel_x, new_second_vel_y,
	// new_first_color, new_second_color
	output logic [95:0]  m_tdata,
	// in_contact, resolved, saturated
	output logic [2:0]   m_tuser
);

	localparam int DS = 6;  // index of the first divider stage

	logic [37:0]   limit_q;
	logic [NS-1:0] v;
	logic [NS-1:0] rdy;

	// Contact limit: store (2r)^2 = 4r^2 on write.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LIMIT_RST;
		end else if (cfg_we) begin
			limit_q <= {36'(cfg_wdata) * 36'(cfg_wdata), 2'b00};
		end
	end

	// Per-stage ready: load when empty or when the next stage moves on.
	always_comb begin
		rdy[NS-1] = !v[NS-1] || m_tready;
		for (int k = NS - 2; k >= 0; k--) begin
			rdy[k] = !v[k] || rdy[k+1];
		end
	end

	assign s_tready = rdy[0];
	assign m_tvalid = v[NS-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v <= '0;
		end else begin
			if (rdy[0]) v[0] <= s_tvalid;
			for (int k = 1; k < NS; k++) begin
				if (rdy[k]) v[k] <= v[k-1];
			end
		end
	end

	// Stage 1: unpack, position and velocity differences.
	pass_t              pass_s1;
	logic signed [20:0] dx_s1, dy_s1;
	logic signed [16:0] dvx_s1, dvy_s1;

	always_ff @(posedge clk) begin
		if (rdy[0]) begin
			dx_s1  <= $signed({1'b0, s_tdata[19:0]})   - $signed({1'b0, s_tdata[107:88]});
			dy_s1  <= $signed({1'b0, s_tdata[39:20]})  - $signed({1'b0, s_tdata[127:108]});
			dvx_s1 <= $signed({s_tdata[55], s_tdata[55:40]})
				- $signed({s_tdata[143], s_tdata[143:128]});
			dvy_s1 <= $signed({s_tdata[71], s_tdata[71:56]})
				- $signed({s_tdata[159], s_tdata[159:144]});
			pass_s1.v1x <= $signed(s_tdata[55:40]);
			pass_s1.v1y <= $signed(s_tdata[71:56]);
			pass_s1.c1  <= s_tdata[87:72];
			pass_s1.v2x <= $signed(s_tdata[143:128]);
			pass_s1.v2y <= $signed(s_tdata[159:144]);
			pass_s1.c2  <= s_tdata[175:160];
		end
	end

	// Stage 2: squares and velocity-position products.
	pass_t              pass_s2;
	logic signed [20:0] dx_s2, dy_s2;
	logic [40:0]        dxx_s2, dyy_s2;
	logic signed [37:0] pxv_s2, pyv_s2;
	logic signed [41:0] sqx, sqy;

	assign sqx = dx_s1 * dx_s1;
	assign sqy = dy_s1 * dy_s1;

	always_ff @(posedge clk) begin
		if (rdy[1]) begin
			pass_s2 <= pass_s1;
			dx_s2   <= dx_s1;
			dy_s2   <= dy_s1;
			dxx_s2  <= sqx[40:0];
			dyy_s2  <= sqy[40:0];
			pxv_s2  <= dvx_s1 * dx_s1;
			pyv_s2  <= dvy_s1 * dy_s1;
		end
	end

	// Stage 3: squared distance, dot product, contact test.
	pass_t              pass_s3;
	logic signed [20:0] dx_s3, dy_s3;
	logic [DW-1:0]      dist2_s3;
	logic signed [38:0] dot_s3;
	logic               contact_s3;
	logic [DW-1:0]      dist2_c;

	assign dist2_c = dxx_s2 + dyy_s2;

	always_ff @(posedge clk) begin
		if (rdy[2]) begin
			pass_s3    <= pass_s2;
			dx_s3      <= dx_s2;
			dy_s3      <= dy_s2;
			dist2_s3   <= dist2_c;
			dot_s3     <= 39'(pxv_s2) + 39'(pyv_s2);
			contact_s3 <= dist2_c <= DW'(limit_q);
		end
	end

	// Stage 4: response decision, magnitudes for the unsigned divide.
	pass_t         pass_s4;
	logic          contact_s4, resolved_s4, sx_s4, sy_s4;
	logic [38:0]   dmag_s4;
	logic [19:0]   ax_s4, ay_s4;
	logic [DW-1:0] den_s4;
	logic [20:0]   negx, negy;

	assign negx = 21'(-dx_s3);
	assign negy = 21'(-dy_s3);

	always_ff @(posedge clk) begin
		if (rdy[3]) begin
			pass_s4     <= pass_s3;
			contact_s4  <= contact_s3;
			resolved_s4 <= contact_s3 && (dist2_s3 != '0) && dot_s3[38];
			// dot is negative when resolved: c opposes dx
			sx_s4       <= !dx_s3[20];
			sy_s4       <= !dy_s3[20];
			dmag_s4     <= dot_s3[38] ? 39'(-dot_s3) : 39'(dot_s3);
			ax_s4       <= dx_s3[20] ? negx[19:0] : dx_s3[19:0];
			ay_s4       <= dy_s3[20] ? negy[19:0] : dy_s3[19:0];
			den_s4      <= dist2_s3;
		end
	end

	// Stage 5: |dot| * |d| as two partial products per axis.
	pass_t         pass_s5;
	logic          contact_s5, resolved_s5, sx_s5, sy_s5;
	logic [DW-1:0] den_s5;
	logic [39:0]   plx_s5, ply_s5;
	logic [38:0]   phx_s5, phy_s5;

	always_ff @(posedge clk) begin
		if (rdy[4]) begin
			pass_s5     <= pass_s4;
			contact_s5  <= contact_s4;
			resolved_s5 <= resolved_s4;
			sx_s5       <= sx_s4;
			sy_s5       <= sy_s4;
			den_s5      <= den_s4;
			plx_s5      <= dmag_s4[19:0] * ax_s4;
			phx_s5      <= dmag_s4[38:20] * ax_s4;
			ply_s5      <= dmag_s4[19:0] * ay_s4;
			phy_s5      <= dmag_s4[38:20] * ay_s4;
		end
	end

	// Stage 6: join partial products, add half the divisor for rounding.
	div_t        div_s6;
	logic [NW-1:0] half;

	assign half = NW'(den_s5 >> 1);

	always_ff @(posedge clk) begin
		if (rdy[5]) begin
			div_s6.pass     <= pass_s5;
			div_s6.contact  <= contact_s5;
			div_s6.resolved <= resolved_s5;
			div_s6.sx       <= sx_s5;
			div_s6.sy       <= sy_s5;
			div_s6.den      <= den_s5;
			div_s6.rx       <= {phx_s5, 20'd0} + NW'(plx_s5) + half;
			div_s6.ry       <= {phy_s5, 20'd0} + NW'(ply_s5) + half;
			div_s6.qx       <= '0;
			div_s6.qy       <= '0;
		end
	end

	// Divider stages: one restoring quotient bit per stage, MSB first.
	div_t div_sd [QW];
	div_t div_nx [QW];

	always_comb begin
		div_t        cur;
		logic [NW-1:0] dsh;
		for (int k = 0; k < QW; k++) begin
			cur = (k == 0) ? div_s6 : div_sd[k-1];
			dsh = NW'(cur.den) << (QW - 1 - k);
			div_nx[k] = cur;
			if (cur.rx >= dsh) begin
				div_nx[k].rx = cur.rx - dsh;
				div_nx[k].qx[QW-1-k] = 1'b1;
			end
			if (cur.ry >= dsh) begin
				div_nx[k].ry = cur.ry - dsh;
				div_nx[k].qy[QW-1-k] = 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < QW; k++) begin
			if (rdy[DS+k]) div_sd[k] <= div_nx[k];
		end
	end

	// Output stage: apply the correction, clamp, swap colors.
	div_t               fin;
	logic signed [19:0] qxs, qys;
	logic signed [19:0] s1x, s1y, s2x, s2y;
	logic [15:0]        o1x, o1y, o2x, o2y;
	logic               t1x, t1y, t2x, t2y;

	assign fin = div_sd[QW-1];
	assign qxs = $signed({2'b00, fin.qx});
	assign qys = $signed({2'b00, fin.qy});
	assign s1x = fin.sx ? 20'(fin.pass.v1x) + qxs : 20'(fin.pass.v1x) - qxs;
	assign s2x = fin.sx ? 20'(fin.pass.v2x) - qxs : 20'(fin.pass.v2x) + qxs;
	assign s1y = fin.sy ? 20'(fin.pass.v1y) + qys : 20'(fin.pass.v1y) - qys;
	assign s2y = fin.sy ? 20'(fin.pass.v2y) - qys : 20'(fin.pass.v2y) + qys;

	function automatic logic [16:0] clamp16(input logic signed [19:0] s);
		logic [16:0] r;
		if (s > 20'sd32767) r = {1'b1, 16'h7FFF};
		else if (s < -20'sd32768) r = {1'b1, 16'h8000};
		else r = {1'b0, s[15:0]};
		return r;
	endfunction

	assign {t1x, o1x} = clamp16(s1x);
	assign {t1y, o1y} = clamp16(s1y);
	assign {t2x, o2x} = clamp16(s2x);
	assign {t2y, o2y} = clamp16(s2y);

	always_ff @(posedge clk) begin
		if (rdy[NS-1]) begin
			if (fin.resolved) begin
				m_tdata <= {fin.pass.c1, fin.pass.c2, o2y, o2x, o1y, o1x};
				m_tuser <= {t1x | t1y | t2x | t2y, 1'b1, fin.contact};
			end else begin
				m_tdata <= {fin.pass.c2, fin.pass.c1, fin.pass.v2y, fin.pass.v2x,
					fin.pass.v1y, fin.pass.v1x};
				m_tuser <= {2'b00, fin.contact};
			end
		end
	end

	`EPC_IMPLIES(a_res_contact, m_tvalid && m_tuser[1], m_tuser[0], "resolved without contact")
	`EPC_IMPLIES(a_sat_res, m_tvalid && !m_tuser[1], !m_tuser[2], "clamp flagged on pass-through")
	`EPC_IMPLIES(a_full_stall, !s_tready, &v, "input held off with a free stage")

endmodule

[tb/tb_elastic_pair_collision.sv]
// Self-checking testbench for elastic_pair_collision: directed and random pairs,
// several contact radii and idle/stall patterns. Depends on epc_pkg and the RTL.
module tb_elastic_pair_collision;
	import epc_pkg::*;

	// One circle pair as it travels on s_tdata.
	typedef struct {
		logic [19:0]        p1x, p1y;
		logic signed [15:0] v1x, v1y;
		logic [15:0]        c1;
		logic [19:0]        p2x, p2y;
		logic signed [15:0] v2x, v2y;
		logic [15:0]        c2;
	} pair_t;

	// One response as it travels on m_tdata / m_tuser.
	typedef struct {
		logic [15:0] n1x, n1y, n2x, n2y, o1, o2;
		logic        contact, resolved, sat;
	} resp_t;

	logic         clk;
	logic         arst_n;
	logic         cfg_we;
	logic [17:0]  cfg_wdata;
	logic         s_tvalid;
	logic         s_tready;
	logic [175:0] s_tdata;
	logic         m_tvalid;
	logic         m_tready;
	logic [95:0]  m_tdata;
	logic [2:0]   m_tuser;

	resp_t pending_resp[$];   // responses owed by the block, oldest first
	longint radius_q;         // our copy of contact_radius
	int src_idle_pct;
	int snk_stall_pct;
	bit failed;

	elastic_pair_collision i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// n / d rounded to nearest, ties away from zero, d > 0.
	function automatic longint div_nearest(longint n, longint d);
		longint mag;
		longint q;
		mag = (n < 0) ? -n : n;
		q = (mag + d / 2) / d;
		return (n < 0) ? -q : q;
	endfunction

	function automatic logic [15:0] clamp_vel(longint v, inout bit sat);
		if (v > 32767) begin
			sat = 1'b1;
			return 16'h7fff;
		end
		if (v < -32768) begin
			sat = 1'b1;
			return 16'h8000;
		end
		return v[15:0];
	endfunction

	// Contact test and equal-mass response for one pair.
	function automatic resp_t collide_pair(pair_t p);
		resp_t  r;
		longint dx, dy, dist2, diam, dot, cx, cy;
		longint a1x, a1y, a2x, a2y;
		bit     sat;
		a1x = p.v1x;
		a1y = p.v1y;
		a2x = p.v2x;
		a2y = p.v2y;
		dx = longint'(p.p1x) - longint'(p.p2x);
		dy = longint'(p.p1y) - longint'(p.p2y);
		dist2 = dx * dx + dy * dy;
		diam = 2 * radius_q;
		dot = (a1x - a2x) * dx + (a1y - a2y) * dy;
		sat = 1'b0;
		r.contact = (dist2 <= diam * diam);
		r.resolved = r.contact && dist2 != 0 && dot < 0;
		r.n1x = p.v1x;
		r.n1y = p.v1y;
		r.n2x = p.v2x;
		r.n2y = p.v2y;
		r.o1 = p.c1;
		r.o2 = p.c2;
		if (r.resolved) begin
			cx = div_nearest(dot * dx, dist2);
			cy = div_nearest(dot * dy, dist2);
			r.n1x = clamp_vel(a1x - cx, sat);
			r.n1y = clamp_vel(a1y - cy, sat);
			r.n2x = clamp_vel(a2x + cx, sat);
			r.n2y = clamp_vel(a2y + cy, sat);
			r.o1 = p.c2;
			r.o2 = p.c1;
		end
		r.sat = sat;
		return r;
	endfunction

	// Hand one pair to the block; the expectation is queued on acceptance.
	task automatic send_pair(pair_t p);
		while ($urandom_range(99) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {p.c2, p.v2y, p.v2x, p.p2y, p.p2x, p.c1, p.v1y, p.v1x, p.p1y, p.p1x};
		do
			@(posedge clk);
		while (!s_tready);
		pending_resp = {pending_resp, collide_pair(p)};
	endtask

	// Drain the pipeline, then write the radius while the block is idle.
	task automatic set_radius(longint r);
		s_tvalid <= 1'b0;
		wait (pending_resp.size() == 0);
		repeat (40) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= r[17:0];
		@(posedge clk);
		cfg_we <= 1'b0;
		radius_q = r;
	endtask

	function automatic logic [19:0] near_pos(logic [19:0] base, longint span);
		longint off, v;
		off = longint'($urandom_range(0, 2 * span)) - span;
		v = longint'(base) - off;
		if (v < 0 || v > 20'hfffff)
			v = longint'(base) + off;
		return v[19:0];
	endfunction

	function automatic logic signed [15:0] rand_vel();
		case ($urandom_range(3))
			0: return $urandom_range(0, 511) - 256;
			1: return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
			default: return $urandom;
		endcase
	endfunction

	// Mostly pairs placed near each other so the contact test passes or just fails.
	function automatic pair_t rand_pair();
		pair_t  p;
		longint span;
		span = 2 * radius_q + 16;
		if (span > 20'hfffff)
			span = 20'hfffff;
		p.p1x = $urandom;
		p.p1y = $urandom;
		p.v1x = rand_vel();
		p.v1y = rand_vel();
		p.c1 = $urandom;
		p.v2x = rand_vel();
		p.v2y = rand_vel();
		p.c2 = $urandom;
		if ($urandom_range(9) < 8) begin
			p.p2x = near_pos(p.p1x, span);
			p.p2y = near_pos(p.p1y, span);
		end else begin
			p.p2x = $urandom;
			p.p2y = $urandom;
		end
		return p;
	endfunction

	function automatic pair_t mk_pair(longint p1x, longint p1y, longint v1x, longint v1y,
			longint p2x, longint p2y, longint v2x, longint v2y);
		pair_t p;
		p.p1x = p1x[19:0];
		p.p1y = p1y[19:0];
		p.v1x = v1x[15:0];
		p.v1y = v1y[15:0];
		p.c1 = $urandom;
		p.p2x = p2x[19:0];
		p.p2y = p2y[19:0];
		p.v2x = v2x[15:0];
		p.v2y = v2y[15:0];
		p.c2 = $urandom;
		return p;
	endfunction

	task automatic test_directed();
		pair_t p;
		// coincident centers: contact, never resolved
		send_pair(mk_pair(0, 0, 0, 0, 0, 0, 0, 0));
		send_pair(mk_pair(20'hfffff, 20'hfffff, -32768, 32767,
			20'hfffff, 20'hfffff, 32767, -32768));
		// head-on along x, approaching and separating
		send_pair(mk_pair(5000, 3000, -256, 0, 3000, 3000, 256, 0));
		send_pair(mk_pair(5000, 3000, 256, 0, 3000, 3000, -256, 0));
		// diagonal hit whose correction clamps, with a rounding tie
		send_pair(mk_pair(1, 1, -32768, 32767, 0, 0, 32767, 32767));
		send_pair(mk_pair(0, 0, 32767, -32768, 1, 1, -32768, -32768));
		// exactly at and just beyond the contact limit (radius 2560)
		send_pair(mk_pair(5120, 0, -100, 0, 0, 0, 100, 0));
		send_pair(mk_pair(5121, 0, -100, 0, 0, 0, 100, 0));
		// far apart at opposite corners
		send_pair(mk_pair(0, 0, 32767, 32767, 20'hfffff, 20'hfffff, -32768, -32768));
		// grazing pass: zero dot product
		send_pair(mk_pair(0, 100, 500, 0, 0, 0, 0, 0));
		p = mk_pair(20'haaaaa, 20'h55555, 16'sh5555, -16'sh5556,
			20'haaaab, 20'h55554, -16'sh5556, 16'sh5555);
		p.c1 = 16'hffff;
		p.c2 = 16'h0000;
		send_pair(p);
		// radius zero: only coincident centers touch
		set_radius(0);
		send_pair(mk_pair(7, 7, 10, 10, 7, 7, -10, -10));
		send_pair(mk_pair(8, 7, -10, 0, 7, 7, 10, 0));
		// maximum radius: opposite corners are still out of contact
		set_radius(262143);
		send_pair(mk_pair(20'hfffff, 0, -32768, 100, 0, 20'hfffff, 32767, -100));
		send_pair(mk_pair(0, 20'hfffff, 32767, 32767, 20'hfffff, 0, 0, 0));
	endtask

	task automatic test_random(int n, int src_pct, int snk_pct);
		src_idle_pct = src_pct;
		snk_stall_pct = snk_pct;
		repeat (n) send_pair(rand_pair());
		src_idle_pct = 0;
		snk_stall_pct = 0;
	endtask

	task automatic chk_field(string name, logic [15:0] exp_v, logic [15:0] act_v);
		if (exp_v !== act_v) begin
			$display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
			failed = 1'b1;
		end
	endtask

	// Sink side: random stall, then check each beat against the oldest expectation.
	always @(posedge clk) begin
		resp_t e;
		m_tready <= ($urandom_range(99) >= snk_stall_pct);
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_resp.size() == 0) begin
				$display("%0t: unexpected beat, actual %h %h", $time, m_tdata, m_tuser);
				failed = 1'b1;
			end else begin
				e = pending_resp.pop_front();
				chk_field("new_first_vel_x", e.n1x, m_tdata[15:0]);
				chk_field("new_first_vel_y", e.n1y, m_tdata[31:16]);
				chk_field("new_second_vel_x", e.n2x, m_tdata[47:32]);
				chk_field("new_second_vel_y", e.n2y, m_tdata[63:48]);
				chk_field("new_first_color", e.o1, m_tdata[79:64]);
				chk_field("new_second_color", e.o2, m_tdata[95:80]);
				chk_field("in_contact", e.contact, m_tuser[0]);
				chk_field("resolved", e.resolved, m_tuser[1]);
				chk_field("saturated", e.sat, m_tuser[2]);
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		radius_q = 2560;
		src_idle_pct = 0;
		snk_stall_pct = 0;
		failed = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		set_radius(2560);
		test_random(450, 0, 0);
		set_radius(1);
		test_random(300, 79, 0);
		set_radius($urandom_range(0, 262143));
		test_random(300, 0, 79);
		set_radius(262143);
		test_random(300, 10, 10);
		set_radius($urandom_range(16, 4096));
		test_random(300, 0, 0);
		set_radius(0);
		test_random(250, 10, 10);
		s_tvalid <= 1'b0;
		wait (pending_resp.size() == 0);
		repeat (40) @(posedge clk);
		if (!failed)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	initial begin
		#3000000;
		$display("Verification failed");
		$finish;
	end

endmodule

[elastic_pair_collision.f]
+incdir+rtl
rtl/epc_pkg.sv
rtl/elastic_pair_collision.sv
tb/tb_elastic_pair_collision.sv
